// ----- hw/rtl/ptsq_pkg.sv -----
// Package for the priority transmit slot queue.
// Sizes, codes, payload structs and the packet RAM address helper.
// No dependencies.
package ptsq_pkg;

	localparam int SLOT_COUNT   = 6;
	localparam int NORMAL_SLOTS = 4;
	localparam int SLOT_BYTES   = 256;

	localparam int NORMAL_LIMIT = (NORMAL_SLOTS < SLOT_COUNT) ? NORMAL_SLOTS : SLOT_COUNT;
	localparam int SLOT_W       = $clog2(SLOT_COUNT);
	localparam int CNT_W        = $clog2(SLOT_BYTES + 1);
	localparam int MEM_DEPTH    = SLOT_COUNT * SLOT_BYTES;
	localparam int ADDR_W       = $clog2(MEM_DEPTH);
	localparam int FREE_W       = $clog2(SLOT_COUNT + 1);

	localparam logic [7:0] PRIO_RESERVED = 8'd2;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_POLL  = 2'd1,
		OP_TXRDY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_QUEUED  = 2'd1,
		ST_DROPPED = 2'd2,
		ST_REFUSED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		LM_IDLE   = 4'b0001,
		LM_LOAD   = 4'b0010,
		LM_REFUSE = 4'b0100,
		LM_DROP   = 4'b1000
	} load_mode_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic       last;
		logic [7:0] priority_req;
		logic       link_up;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  enqueue_status;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        tx_enable;
		logic        normal_space;
		logic [2:0]  free_slots;
		logic [31:0] drop_count;
	} out_item_t;

	// Byte address of position pos inside slot.
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
							input logic [CNT_W-1:0] pos);
		return ADDR_W'(ADDR_W'(slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos));
	endfunction

endpackage

// ----- hw/rtl/ptsq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module ptsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/priority_tx_slot_queue_unit.sv -----
// Priority transmit slot queue, top level.
// Uses ptsq_pkg (scoped names) and ptsq_ram for the packet store.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid / in_ready   | in_item  (ptsq_pkg::in_item_t)
//  out     | output    | out_valid / out_ready | out_item (ptsq_pkg::out_item_t)
//
// One transaction in per clock; its result shows the cycle after acceptance.
// All state updates for a transaction happen at the accepting edge; the packet
// RAM read for a transmitter-ready transaction lands in the RAM output register
// at that same edge, alongside the result register.
// in_ready is high while the result register is empty or being taken, so a
// stalled output holds one result and stops intake; no transaction is lost.
// Reset clears all control state at once; the packet RAM is not cleared and
// needs no clearing pass (only written bytes are ever sent).
module priority_tx_slot_queue_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ptsq_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ptsq_pkg::out_item_t  out_item
);

	localparam int SC = ptsq_pkg::SLOT_COUNT;
	localparam int SW = ptsq_pkg::SLOT_W;
	localparam int CW = ptsq_pkg::CNT_W;

	// ---------------- state ----------------
	logic                     ready_q  [SC];
	logic [CW-1:0]            len_q    [SC];
	logic [7:0]               prio_q   [SC];
	logic [31:0]              order_q  [SC];
	logic [31:0]              order_cnt_q;
	logic                     active_valid_q;
	logic [SW-1:0]            active_slot_q;
	logic [CW-1:0]            send_pos_q;
	logic                     link_was_up_q;
	logic [31:0]              drop_cnt_q;
	logic                     tx_en_q;
	logic [SW-1:0]            load_slot_q;
	logic [CW-1:0]            load_cnt_q;
	ptsq_pkg::load_mode_t     load_mode_q;

	// Result stage
	logic                     out_valid_q;
	ptsq_pkg::status_t        status_s1;
	logic                     txv_s1;

	// ---------------- next state ----------------
	logic                     ready_d  [SC];
	logic [CW-1:0]            len_d    [SC];
	logic [7:0]               prio_d   [SC];
	logic [31:0]              order_d  [SC];
	logic [31:0]              order_cnt_d;
	logic                     active_valid_d;
	logic [SW-1:0]            active_slot_d;
	logic [CW-1:0]            send_pos_d;
	logic                     link_was_up_d;
	logic [31:0]              drop_cnt_d;
	logic                     tx_en_d;
	logic [SW-1:0]            load_slot_d;
	logic [CW-1:0]            load_cnt_d;
	ptsq_pkg::load_mode_t     load_mode_d;
	ptsq_pkg::status_t        status_d;
	logic                     txv_d;

	logic                     accept;
	logic                     free_now [SC];
	logic [SC-1:0]            flush_mask;
	logic [SC-1:0]            beat     [SC];
	logic                     best_found;
	logic [SW-1:0]            best_slot;
	logic [ptsq_pkg::FREE_W-1:0] free_n;
	logic                     normal_n;

	logic                           ram_wr_en;
	logic [ptsq_pkg::ADDR_W-1:0]    ram_wr_addr;
	logic                           ram_rd_en;
	logic [7:0]                     ram_rd_data;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// A slot is free when it holds no queued packet and is not being sent.
	// A slot under load is not ready yet, so it still counts as free.
	always_comb begin
		for (int i = 0; i < SC; i++) begin
			free_now[i]   = !ready_q[i] && !(active_valid_q && active_slot_q == SW'(i));
			flush_mask[i] = ready_q[i] && !(active_valid_q && active_slot_q == SW'(i));
		end
	end

	// Pairwise "slot i beats slot j" (j < i): higher priority, or equal priority
	// and older by wrapping order tag. All pairs in parallel; the scan below
	// then only walks 1-bit lookups, matching a first-to-last scan exactly.
	always_comb begin
		logic [31:0] diff;
		for (int i = 0; i < SC; i++) begin
			beat[i] = '0;
			for (int j = 0; j < i; j++) begin
				diff       = order_q[i] - order_q[j];
				beat[i][j] = (prio_q[i] > prio_q[j]) ||
					     ((prio_q[i] == prio_q[j]) && diff[31]);
			end
		end
	end

	always_comb begin
		best_found = 1'b0;
		best_slot  = '0;
		for (int i = 0; i < SC; i++) begin
			if (ready_q[i] && (!best_found || beat[i][best_slot])) begin
				best_found = 1'b1;
				best_slot  = SW'(i);
			end
		end
	end

	// Occupancy summary, taken from the state the last transaction left.
	always_comb begin
		free_n   = '0;
		normal_n = 1'b0;
		for (int i = 0; i < SC; i++) begin
			if (free_now[i]) begin
				free_n = free_n + 1'b1;
				if (i < ptsq_pkg::NORMAL_LIMIT) begin
					normal_n = 1'b1;
				end
			end
		end
	end

	// Transaction decode and state update.
	always_comb begin
		ptsq_pkg::load_mode_t mode;
		logic [SW-1:0]        lslot;
		logic [CW-1:0]        lcnt;
		logic                 found;

		ready_d        = ready_q;
		len_d          = len_q;
		prio_d         = prio_q;
		order_d        = order_q;
		order_cnt_d    = order_cnt_q;
		active_valid_d = active_valid_q;
		active_slot_d  = active_slot_q;
		send_pos_d     = send_pos_q;
		link_was_up_d  = link_was_up_q;
		drop_cnt_d     = drop_cnt_q;
		tx_en_d        = tx_en_q;
		load_slot_d    = load_slot_q;
		load_cnt_d     = load_cnt_q;
		load_mode_d    = load_mode_q;
		status_d       = ptsq_pkg::ST_NONE;
		txv_d          = 1'b0;
		ram_wr_en      = 1'b0;
		ram_rd_en      = 1'b0;

		mode  = load_mode_q;
		lslot = load_slot_q;
		lcnt  = load_cnt_q;
		found = 1'b0;

		ram_wr_addr = ptsq_pkg::slot_addr(lslot, lcnt);

		case (ptsq_pkg::op_t'(in_item.operation))
			ptsq_pkg::OP_LOAD: begin
				// First byte: link check and slot pick.
				if (mode == ptsq_pkg::LM_IDLE) begin
					if (!in_item.link_up) begin
						mode = ptsq_pkg::LM_REFUSE;
					end else begin
						mode = ptsq_pkg::LM_DROP;
						for (int i = 0; i < SC; i++) begin
							if (!found && free_now[i] &&
							    (in_item.priority_req == ptsq_pkg::PRIO_RESERVED ||
							     i < ptsq_pkg::NORMAL_LIMIT)) begin
								found = 1'b1;
								lslot = SW'(i);
							end
						end
						if (found) begin
							mode          = ptsq_pkg::LM_LOAD;
							lcnt          = '0;
							prio_d[lslot] = in_item.priority_req;
						end
					end
				end
				// Store the byte, or turn an overlong packet into a drop.
				if (mode == ptsq_pkg::LM_LOAD) begin
					if (lcnt >= CW'(ptsq_pkg::SLOT_BYTES)) begin
						mode = ptsq_pkg::LM_DROP;
					end else begin
						ram_wr_en   = accept;
						ram_wr_addr = ptsq_pkg::slot_addr(lslot, lcnt);
						lcnt        = lcnt + 1'b1;
					end
				end
				if (in_item.last) begin
					case (mode)
						ptsq_pkg::LM_LOAD: begin
							len_d[lslot]   = lcnt;
							order_d[lslot] = order_cnt_q;
							order_cnt_d    = order_cnt_q + 32'd1;
							ready_d[lslot] = 1'b1;
							status_d       = ptsq_pkg::ST_QUEUED;
						end
						ptsq_pkg::LM_REFUSE: begin
							status_d = ptsq_pkg::ST_REFUSED;
						end
						default: begin
							drop_cnt_d = drop_cnt_q + 32'd1;
							status_d   = ptsq_pkg::ST_DROPPED;
						end
					endcase
					mode = ptsq_pkg::LM_IDLE;
				end
				load_mode_d = mode;
				load_slot_d = lslot;
				load_cnt_d  = lcnt;
			end
			ptsq_pkg::OP_POLL: begin
				if (!in_item.link_up) begin
					// Link lost: drop every queued slot but the one on air.
					if (link_was_up_q) begin
						for (int i = 0; i < SC; i++) begin
							if (flush_mask[i]) begin
								ready_d[i] = 1'b0;
							end
						end
						drop_cnt_d = drop_cnt_q + 32'($countones(flush_mask));
					end
					link_was_up_d = 1'b0;
				end else begin
					link_was_up_d = 1'b1;
					if (!active_valid_q && best_found) begin
						send_pos_d     = '0;
						active_slot_d  = best_slot;
						active_valid_d = 1'b1;
						tx_en_d        = 1'b1;
					end
				end
			end
			ptsq_pkg::OP_TXRDY: begin
				if (!active_valid_q) begin
					tx_en_d = 1'b0;
				end else begin
					ram_rd_en  = accept;
					txv_d      = 1'b1;
					send_pos_d = send_pos_q + 1'b1;
					if (send_pos_d >= len_q[active_slot_q]) begin
						ready_d[active_slot_q] = 1'b0;
						active_valid_d         = 1'b0;
						tx_en_d                = 1'b0;
					end
				end
			end
			default: begin
				// Unused code: status only.
			end
		endcase
	end

	// Packet store: one write port for loads, one read port for transmit.
	ptsq_ram #(
		.WIDTH(8),
		.DEPTH(ptsq_pkg::MEM_DEPTH)
	) u_pkt_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (in_item.data_byte),
		.rd_en   (ram_rd_en),
		.rd_addr (ptsq_pkg::slot_addr(active_slot_q, send_pos_q)),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SC; i++) begin
				ready_q[i] <= 1'b0;
				len_q[i]   <= '0;
				prio_q[i]  <= '0;
				order_q[i] <= '0;
			end
			order_cnt_q    <= '0;
			active_valid_q <= 1'b0;
			active_slot_q  <= '0;
			send_pos_q     <= '0;
			link_was_up_q  <= 1'b0;
			drop_cnt_q     <= '0;
			tx_en_q        <= 1'b0;
			load_slot_q    <= '0;
			load_cnt_q     <= '0;
			load_mode_q    <= ptsq_pkg::LM_IDLE;
			out_valid_q    <= 1'b0;
			status_s1      <= ptsq_pkg::ST_NONE;
			txv_s1         <= 1'b0;
		end else begin
			if (accept) begin
				ready_q        <= ready_d;
				len_q          <= len_d;
				prio_q         <= prio_d;
				order_q        <= order_d;
				order_cnt_q    <= order_cnt_d;
				active_valid_q <= active_valid_d;
				active_slot_q  <= active_slot_d;
				send_pos_q     <= send_pos_d;
				link_was_up_q  <= link_was_up_d;
				drop_cnt_q     <= drop_cnt_d;
				tx_en_q        <= tx_en_d;
				load_slot_q    <= load_slot_d;
				load_cnt_q     <= load_cnt_d;
				load_mode_q    <= load_mode_d;
				status_s1      <= status_d;
				txv_s1         <= txv_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q    <= 1'b0;
			end
		end
	end

	// State only moves on acceptance, so the summary fields read straight
	// from the state registers stay put while the result waits.
	assign out_valid               = out_valid_q;
	assign out_item.enqueue_status = status_s1;
	assign out_item.tx_valid       = txv_s1;
	assign out_item.tx_byte        = txv_s1 ? ram_rd_data : 8'd0;
	assign out_item.tx_enable      = tx_en_q;
	assign out_item.normal_space   = normal_n;
	assign out_item.free_slots     = 3'(free_n);
	assign out_item.drop_count     = drop_cnt_q;

endmodule

// ----- hw/rtl/ptsq_checker.sv -----
// Port-level checker for priority_tx_slot_queue_unit, with its bind.
// Uses ptsq_pkg (scoped names).
module ptsq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input ptsq_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input ptsq_pkg::out_item_t out_item
);

	// A held result does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Every accepted transaction has its result next cycle.
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction without result");

	// Only loads report an enqueue outcome.
	a_status_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.operation != ptsq_pkg::OP_LOAD
		|=> out_item.enqueue_status == ptsq_pkg::ST_NONE)
		else $error("status on a non-load transaction");

	// No byte shown unless flagged valid.
	a_tx_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.tx_valid |-> out_item.tx_byte == 8'd0)
		else $error("tx_byte set without tx_valid");

	// Normal space implies at least one free slot.
	a_space_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.normal_space |-> out_item.free_slots != 3'd0)
		else $error("normal_space with no free slots");

endmodule

bind priority_tx_slot_queue_unit ptsq_checker u_ptsq_checker (.*);

// ----- verif/tb_priority_tx_slot_queue_unit.sv -----
// Testbench for priority_tx_slot_queue_unit: drives load, poll and transmit-ready transactions
// and checks every result against a cycle-free model of the slot queue kept in a scoreboard.
// Depends on ptsq_pkg and the RTL of priority_tx_slot_queue_unit only.
module tb_priority_tx_slot_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1350;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SW           = ptsq_pkg::SLOT_W;
	localparam int CW           = ptsq_pkg::CNT_W;
	localparam int IN_W         = $bits(ptsq_pkg::in_item_t);

	// Scoreboard: keeps its own copy of the queue state. Each accepted input
	// transaction advances that state and yields one expected result.
	class slot_queue_scoreboard;
		logic [7:0]            pkt_mem [ptsq_pkg::MEM_DEPTH];
		logic [CW-1:0]         pkt_len [ptsq_pkg::SLOT_COUNT];
		logic [7:0]            pkt_prio [ptsq_pkg::SLOT_COUNT];
		bit                    pkt_ready [ptsq_pkg::SLOT_COUNT];
		logic [31:0]           pkt_tag [ptsq_pkg::SLOT_COUNT];
		logic [31:0]           tag_next;
		bit                    sending;
		logic [SW-1:0]         send_slot;
		logic [CW-1:0]         send_pos;
		bit                    link_seen_up;
		logic [31:0]           drops;
		bit                    tx_en;
		logic [SW-1:0]         fill_slot;
		logic [CW-1:0]         fill_count;
		ptsq_pkg::load_mode_t  fill_mode;
		ptsq_pkg::out_item_t   expected_q [$];
		int                    errors, n_queued, n_dropped, n_refused, n_sent;

		function new();
			for (int i = 0; i < ptsq_pkg::SLOT_COUNT; i++) begin
				pkt_len[i]   = '0;
				pkt_prio[i]  = '0;
				pkt_ready[i] = 1'b0;
				pkt_tag[i]   = '0;
			end
			tag_next     = '0;
			sending      = 1'b0;
			send_slot    = '0;
			send_pos     = '0;
			link_seen_up = 1'b0;
			drops        = '0;
			tx_en        = 1'b0;
			fill_slot    = '0;
			fill_count   = '0;
			fill_mode    = ptsq_pkg::LM_IDLE;
		endfunction

		function bit is_free(int i);
			return !pkt_ready[i] && !(sending && send_slot == i);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_input(ptsq_pkg::in_item_t it);
			ptsq_pkg::out_item_t r;
			ptsq_pkg::status_t   st;
			int                  lim;
			int                  best;
			bit                  found;
			int                  free_n;
			bit                  normal;
			logic [31:0]         tag_gap;

			r  = '0;
			st = ptsq_pkg::ST_NONE;
			case (it.operation)
				ptsq_pkg::OP_LOAD: begin
					// slot and link are decided on the first byte of a packet
					if (fill_mode == ptsq_pkg::LM_IDLE) begin
						lim = (it.priority_req == ptsq_pkg::PRIO_RESERVED) ?
						      ptsq_pkg::SLOT_COUNT : ptsq_pkg::NORMAL_LIMIT;
						if (!it.link_up) begin
							fill_mode = ptsq_pkg::LM_REFUSE;
						end else begin
							fill_mode = ptsq_pkg::LM_DROP;
							for (int i = 0; i < lim; i++) begin
								if (fill_mode == ptsq_pkg::LM_DROP && is_free(i)) begin
									fill_mode      = ptsq_pkg::LM_LOAD;
									fill_slot      = SW'(i);
									fill_count     = '0;
									pkt_prio[i]    = it.priority_req;
								end
							end
						end
					end
					if (fill_mode == ptsq_pkg::LM_LOAD) begin
						if (fill_count >= ptsq_pkg::SLOT_BYTES) begin
							fill_mode = ptsq_pkg::LM_DROP;
						end else begin
							pkt_mem[ptsq_pkg::slot_addr(fill_slot, fill_count)] =
								it.data_byte;
							fill_count++;
						end
					end
					if (it.last) begin
						case (fill_mode)
							ptsq_pkg::LM_LOAD: begin
								pkt_len[fill_slot]   = fill_count;
								pkt_tag[fill_slot]   = tag_next;
								tag_next++;
								pkt_ready[fill_slot] = 1'b1;
								st = ptsq_pkg::ST_QUEUED;
								n_queued++;
							end
							ptsq_pkg::LM_REFUSE: begin
								st = ptsq_pkg::ST_REFUSED;
								n_refused++;
							end
							default: begin
								drops++;
								st = ptsq_pkg::ST_DROPPED;
								n_dropped++;
							end
						endcase
						fill_mode = ptsq_pkg::LM_IDLE;
					end
				end
				ptsq_pkg::OP_POLL: begin
					if (!it.link_up) begin
						// link lost: everything pending except the active packet goes
						if (link_seen_up) begin
							for (int i = 0; i < ptsq_pkg::SLOT_COUNT; i++) begin
								if (pkt_ready[i] && !(sending && send_slot == i)) begin
									pkt_ready[i] = 1'b0;
									drops++;
								end
							end
						end
						link_seen_up = 1'b0;
					end else begin
						link_seen_up = 1'b1;
						if (!sending) begin
							found = 1'b0;
							best  = 0;
							for (int i = 0; i < ptsq_pkg::SLOT_COUNT; i++) begin
								tag_gap = pkt_tag[i] - pkt_tag[best];
								if (pkt_ready[i] && (!found || pkt_prio[i] > pkt_prio[best] ||
								    (pkt_prio[i] == pkt_prio[best] && tag_gap[31]))) begin
									best  = i;
									found = 1'b1;
								end
							end
							if (found) begin
								send_pos  = '0;
								send_slot = SW'(best);
								sending   = 1'b1;
								tx_en     = 1'b1;
							end
						end
					end
				end
				ptsq_pkg::OP_TXRDY: begin
					if (!sending) begin
						tx_en = 1'b0;
					end else begin
						r.tx_byte  = pkt_mem[ptsq_pkg::slot_addr(send_slot, send_pos)];
						r.tx_valid = 1'b1;
						send_pos++;
						n_sent++;
						if (send_pos >= pkt_len[send_slot]) begin
							pkt_ready[send_slot] = 1'b0;
							sending = 1'b0;
							tx_en   = 1'b0;
						end
					end
				end
				default: ;
			endcase

			free_n = 0;
			normal = 1'b0;
			for (int i = 0; i < ptsq_pkg::SLOT_COUNT; i++) begin
				if (is_free(i)) begin
					free_n++;
					if (i < ptsq_pkg::NORMAL_LIMIT)
						normal = 1'b1;
				end
			end
			r.enqueue_status = st;
			r.tx_enable      = tx_en;
			r.normal_space   = normal;
			r.free_slots     = 3'(free_n);
			r.drop_count     = drops;
			expected_q.push_back(r);
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(ptsq_pkg::out_item_t got);
			ptsq_pkg::out_item_t want;
			if (expected_q.size() == 0) begin
				$error("result with no transaction outstanding: %p", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			field_check("enqueue_status", 32'(want.enqueue_status), 32'(got.enqueue_status));
			field_check("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
			field_check("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
			field_check("tx_enable", 32'(want.tx_enable), 32'(got.tx_enable));
			field_check("normal_space", 32'(want.normal_space), 32'(got.normal_space));
			field_check("free_slots", 32'(want.free_slots), 32'(got.free_slots));
			field_check("drop_count", want.drop_count, got.drop_count);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	ptsq_pkg::in_item_t  in_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	ptsq_pkg::out_item_t out_item;

	slot_queue_scoreboard sb = new();

	int unsigned cycles = 0;
	int          items = 0;          // accepted transactions that the block acts on
	int          send_gap_pct = 0;   // chance, drawn anew after each idle, that the sender idles before a transaction
	int          recv_stall_pct = 0; // chance per cycle that the receiver holds off

	priority_tx_slot_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Global watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: check each accepted result, then pick the next ready level.
	// Registered values are sampled as they stood before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Present one transaction and hold it until accepted. An optional idle
	// gap comes first; valid is only ever lowered or raised once per edge.
	task automatic send_item(input ptsq_pkg::in_item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			in_item  <= ptsq_pkg::in_item_t'(IN_W'($urandom));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(it);
		if (it.operation != ptsq_pkg::OP_NONE)
			items++;
	endtask

	// Non-load transaction; the fields it ignores carry random noise.
	task automatic send_op(input ptsq_pkg::op_t op, input bit link);
		ptsq_pkg::in_item_t it;
		it           = ptsq_pkg::in_item_t'(IN_W'($urandom));
		it.operation = op;
		it.link_up   = link;
		send_item(it);
	endtask

	// Whole packet of len bytes. fill < 0 gives random bytes. Only the first
	// byte's priority and link matter; the second byte flips the link, later ones
	// randomize it, and later bytes scramble the priority, to show both are ignored mid-packet.
	task automatic load_packet(input int len, input logic [7:0] prio, input bit link,
				   input int fill);
		ptsq_pkg::in_item_t it;
		for (int k = 0; k < len; k++) begin
			it.operation    = ptsq_pkg::OP_LOAD;
			it.data_byte    = (fill < 0) ? 8'($urandom) : 8'(fill);
			it.last         = (k == len - 1);
			it.priority_req = (k == 0) ? prio : 8'($urandom);
			it.link_up      = (k == 0) ? link : (k == 1) ? !link : 1'($urandom);
			send_item(it);
		end
	endtask

	initial begin : stimulus
		int          pick;
		int          len;
		int          sel;
		logic [7:0]  prio;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, no idling.
		send_op(ptsq_pkg::OP_TXRDY, 1'b1);    // nothing active: requests stay off
		load_packet(1, 8'hFF, 1'b0, 8'hFF);   // link down on first byte: refused
		send_op(ptsq_pkg::OP_POLL, 1'b1);     // empty queue, link now seen up
		load_packet(2, ptsq_pkg::PRIO_RESERVED, 1'b1, 8'h00);
		load_packet(1, 8'h00, 1'b1, 8'hFF);
		send_op(ptsq_pkg::OP_POLL, 1'b1);     // higher priority packet wins
		send_op(ptsq_pkg::OP_POLL, 1'b1);     // already sending: no new pick
		send_op(ptsq_pkg::OP_TXRDY, 1'b1);
		send_op(ptsq_pkg::OP_TXRDY, 1'b1);    // last byte frees the slot
		repeat (3) load_packet(1, 8'h01, 1'b1, -1);
		load_packet(3, 8'h01, 1'b1, -1);      // normal slots full: dropped, counted once
		load_packet(1, ptsq_pkg::PRIO_RESERVED, 1'b1, -1); // reserved slot still open
		send_op(ptsq_pkg::OP_POLL, 1'b1);
		send_op(ptsq_pkg::OP_POLL, 1'b0);     // link lost: pending flushed, active kept
		send_op(ptsq_pkg::OP_TXRDY, 1'b0);
		send_op(ptsq_pkg::OP_NONE, 1'b1);
		load_packet(2, 8'h07, 1'b1, -1);      // link drops mid-packet: still queued
		send_op(ptsq_pkg::OP_POLL, 1'b1);
		send_op(ptsq_pkg::OP_TXRDY, 1'b1);
		send_op(ptsq_pkg::OP_TXRDY, 1'b1);
		send_op(ptsq_pkg::OP_TXRDY, 1'b1);    // nothing left to send: requests stay off

		// Random traffic in four idling phases: none, sender gaps, receiver
		// stalls, then light gaps on both sides.
		while (items < RANDOM_ITEMS) begin
			case (items * 4 / RANDOM_ITEMS)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 54; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 54; end
				default: begin send_gap_pct = 8; recv_stall_pct = 8; end
			endcase
			pick = $urandom_range(99);
			if (pick < 34) begin
				// mostly short packets; now and then one near or past a full slot
				len = ($urandom_range(39) == 0) ? $urandom_range(250, 262)
								: $urandom_range(1, 8);
				sel = $urandom_range(9);
				prio = (sel < 3) ? ptsq_pkg::PRIO_RESERVED : (sel < 5) ? 8'h00 :
				       (sel == 5) ? 8'hFF : (sel == 6) ? 8'h01 : 8'($urandom);
				load_packet(len, prio, ($urandom_range(9) != 0), -1);
			end else if (pick < 54) begin
				send_op(ptsq_pkg::OP_POLL, ($urandom_range(7) != 0));
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 10)) send_op(ptsq_pkg::OP_TXRDY, 1'($urandom));
			end else begin
				send_op(ptsq_pkg::OP_NONE, 1'($urandom));
			end
		end
		in_valid <= 1'b0;

		// Drain, then keep the clock running to catch any stray result.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d transactions in %0d cycles: %0d packets queued, %0d dropped,",
			 items, cycles, sb.n_queued, sb.n_dropped);
		$display("%0d refused on link down, %0d bytes sent, drop counter at %0d.",
			 sb.n_refused, sb.n_sent, sb.drops);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- priority_tx_slot_queue_unit.f -----
hw/rtl/ptsq_pkg.sv
hw/rtl/ptsq_ram.sv
hw/rtl/priority_tx_slot_queue_unit.sv
hw/rtl/ptsq_checker.sv
verif/tb_priority_tx_slot_queue_unit.sv
